[sv/slms_pkg.sv]
// Shared types and codes for the scissor lift motion sequencer.
`timescale 1ns / 1ps

package slms_pkg;

  localparam logic [15:0] DUR_SAT          = 16'hFFFF;
  localparam logic [15:0] VALVE_DELAY_RST  = 16'd500;
  localparam logic [15:0] HOLD_RST         = 16'd1000;

  typedef enum logic [1:0] {
    ACT_POLL      = 2'd0,
    ACT_ESTOP     = 2'd1,
    ACT_CURTAIN   = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_VALVE_DELAY = 1'b0,
    CFG_HOLD        = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    LS_IDLE      = 3'd0,
    LS_RISING    = 3'd1,
    LS_DROPPING  = 3'd2,
    LS_LOCKED    = 3'd3,
    LS_REFILLING = 3'd4
  } lift_state_t;

  typedef enum logic [3:0] {
    EV_NONE          = 4'd0,
    EV_UP_START      = 4'd1,
    EV_UP_STOP_LIMIT = 4'd2,
    EV_UP_STOP_REL   = 4'd3,
    EV_DOWN_START    = 4'd4,
    EV_DOWN_STOP     = 4'd5,
    EV_LOCK_START    = 4'd6,
    EV_LOCK_STOP     = 4'd7,
    EV_REFILL_START  = 4'd8,
    EV_REFILL_STOP   = 4'd9
  } log_event_t;

  typedef enum logic [6:0] {
    SS_IDLE   = 7'b000_0001,
    SS_RISING = 7'b000_0010,
    SS_DPREP  = 7'b000_0100,
    SS_DHOLD  = 7'b000_1000,
    SS_DROP   = 7'b001_0000,
    SS_LOCK   = 7'b010_0000,
    SS_REFILL = 7'b100_0000
  } sub_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        up_button;
    logic        down_button;
    logic        lock_button;
    logic        refill_button;
    logic        upper_limit_in;
    logic        lower_limit_in;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        motor_on;
    logic        drop_valve_on;
    logic        air_valve_on;
    logic [2:0]  lift_state;
    logic [3:0]  log_event;
    logic [15:0] event_duration;
  } out_item_t;

endpackage

[sv/scissor_lift_motion_sequencer.sv]
// Scissor lift motion sequencer: request register, sequencer logic and result register.
//
// Usage: each input request is a poll tick (buttons, limit switches, ms time)
// or an estop, light curtain or clear alarm event, offered on in_valid/in_data
// and taken at an edge where in_valid is high and in_stall low. Every request
// yields exactly one result on out_valid/out_data, taken when out_stall is low.
// Results are registered: a request passes the request register, then the
// result register, and a stalled result can keep it in the request register.
// Throughput: one request per cycle while out_stall is low, set by the single
// pass of sequencer logic between the two registers; the sequencer state
// updates as a request moves into the result register.
// When the receiver stalls, the result register holds its result and the
// request register still takes one more request; in_stall rises only while
// both registers are full and the result is stalled.
// Configuration: cfg_we writes cfg_wdata into valve delay (index 0) or hold
// time (index 1); write only while the block is idle.
// Reset (rst_n low, synchronous): both registers empty, sequencer idle,
// drives off, valve delay 500 ms and hold time 1000 ms.
`timescale 1ns / 1ps

module scissor_lift_motion_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  slms_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slms_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);

  logic                 in_vld_r;
  slms_pkg::in_item_t   in_r;
  logic                 out_vld_r;
  slms_pkg::out_item_t  out_r;
  logic [15:0]          valve_delay_r;
  logic [15:0]          hold_r;

  slms_pkg::sub_state_t  sub_r, sub_nxt;
  logic [31:0]           start_r, start_nxt;
  logic                  prev_up_r, prev_up_nxt;
  logic                  prev_down_r, prev_down_nxt;
  logic                  prev_lock_r, prev_lock_nxt;
  logic                  motor_r, motor_nxt;
  logic                  drop_r, drop_nxt;
  logic                  air_r, air_nxt;
  slms_pkg::lift_state_t lift_r, lift_nxt;
  slms_pkg::log_event_t  ev;
  logic [15:0]           dur;
  logic [31:0]           elapsed;
  logic [15:0]           dur_sat;
  logic                  out_free;
  logic                  adv;

  assign out_free  = !out_vld_r || !out_stall;
  assign adv       = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign elapsed = in_r.now_ms - start_r;
  assign dur_sat = (elapsed[31:16] != 16'd0) ? slms_pkg::DUR_SAT : elapsed[15:0];

  always_comb begin
    sub_nxt       = sub_r;
    start_nxt     = start_r;
    prev_up_nxt   = prev_up_r;
    prev_down_nxt = prev_down_r;
    prev_lock_nxt = prev_lock_r;
    motor_nxt     = motor_r;
    drop_nxt      = drop_r;
    air_nxt       = air_r;
    lift_nxt      = lift_r;
    ev            = slms_pkg::EV_NONE;
    dur           = 16'd0;

    priority if (in_r.action == slms_pkg::ACT_ESTOP ||
                 in_r.action == slms_pkg::ACT_CURTAIN) begin
      {motor_nxt, drop_nxt, air_nxt} = 3'b000;
      sub_nxt = slms_pkg::SS_IDLE;
    end else if (in_r.action == slms_pkg::ACT_CLEAR) begin
      sub_nxt = slms_pkg::SS_IDLE;
    end else begin
      prev_up_nxt   = in_r.up_button;
      prev_down_nxt = in_r.down_button;
      prev_lock_nxt = in_r.lock_button;
      if (in_r.up_button && in_r.down_button) begin
        // both pressed: stop everything
        {motor_nxt, drop_nxt, air_nxt} = 3'b000;
        if (sub_r != slms_pkg::SS_IDLE) begin
          sub_nxt  = slms_pkg::SS_IDLE;
          lift_nxt = slms_pkg::LS_IDLE;
        end
      end else begin
        unique case (sub_r)
          slms_pkg::SS_IDLE: begin
            priority if (in_r.up_button && in_r.refill_button && !in_r.lock_button) begin
              {motor_nxt, drop_nxt, air_nxt} = 3'b100;
              start_nxt = in_r.now_ms;
              sub_nxt   = slms_pkg::SS_REFILL;
              lift_nxt  = slms_pkg::LS_REFILLING;
              ev        = slms_pkg::EV_REFILL_START;
            end else if (in_r.lock_button && !prev_lock_r) begin
              {motor_nxt, drop_nxt, air_nxt} = 3'b010;
              start_nxt = in_r.now_ms;
              sub_nxt   = slms_pkg::SS_LOCK;
              lift_nxt  = slms_pkg::LS_LOCKED;
              ev        = slms_pkg::EV_LOCK_START;
            end else if (in_r.up_button && !prev_up_r && !in_r.lock_button &&
                         !in_r.upper_limit_in) begin
              motor_nxt = 1'b1;
              start_nxt = in_r.now_ms;
              sub_nxt   = slms_pkg::SS_RISING;
              lift_nxt  = slms_pkg::LS_RISING;
              ev        = slms_pkg::EV_UP_START;
            end else if (in_r.down_button && !prev_down_r) begin
              motor_nxt = 1'b1;
              start_nxt = in_r.now_ms;
              sub_nxt   = slms_pkg::SS_DPREP;
              lift_nxt  = slms_pkg::LS_DROPPING;
              ev        = slms_pkg::EV_DOWN_START;
            end else begin
              sub_nxt = slms_pkg::SS_IDLE;
            end
          end
          slms_pkg::SS_RISING: begin
            if (in_r.upper_limit_in || !in_r.up_button) begin
              dur = dur_sat;
              {motor_nxt, drop_nxt, air_nxt} = 3'b000;
              sub_nxt  = slms_pkg::SS_IDLE;
              lift_nxt = slms_pkg::LS_IDLE;
              ev = in_r.upper_limit_in ? slms_pkg::EV_UP_STOP_LIMIT
                                       : slms_pkg::EV_UP_STOP_REL;
            end
          end
          slms_pkg::SS_DPREP, slms_pkg::SS_DHOLD, slms_pkg::SS_DROP: begin
            priority if (!in_r.down_button) begin
              dur = dur_sat;
              {motor_nxt, drop_nxt, air_nxt} = 3'b000;
              sub_nxt  = slms_pkg::SS_IDLE;
              lift_nxt = slms_pkg::LS_IDLE;
              ev       = slms_pkg::EV_DOWN_STOP;
            end else if (in_r.lower_limit_in) begin
              {motor_nxt, drop_nxt, air_nxt} = 3'b010;
              sub_nxt  = slms_pkg::SS_DROP;
              lift_nxt = slms_pkg::LS_DROPPING;
            end else if (in_r.upper_limit_in || in_r.lock_button) begin
              // forced fast drop
              {motor_nxt, drop_nxt, air_nxt} = 3'b011;
              sub_nxt  = slms_pkg::SS_DROP;
              lift_nxt = slms_pkg::LS_DROPPING;
            end else if (sub_r == slms_pkg::SS_DPREP) begin
              if (elapsed >= {16'd0, valve_delay_r}) begin
                air_nxt = 1'b1;
                sub_nxt = slms_pkg::SS_DHOLD;
              end
            end else if (sub_r == slms_pkg::SS_DHOLD) begin
              if (elapsed >= {16'd0, hold_r}) begin
                motor_nxt = 1'b0;
                drop_nxt  = 1'b1;
                sub_nxt   = slms_pkg::SS_DROP;
              end
            end else begin
              sub_nxt = slms_pkg::SS_DROP;
            end
          end
          slms_pkg::SS_LOCK: begin
            if (!in_r.lock_button) begin
              dur = dur_sat;
              {motor_nxt, drop_nxt, air_nxt} = 3'b000;
              sub_nxt  = slms_pkg::SS_IDLE;
              lift_nxt = slms_pkg::LS_IDLE;
              ev       = slms_pkg::EV_LOCK_STOP;
            end else begin
              {motor_nxt, drop_nxt, air_nxt} = 3'b010;
            end
          end
          slms_pkg::SS_REFILL: begin
            if (!in_r.up_button || !in_r.refill_button || in_r.lock_button) begin
              dur = dur_sat;
              {motor_nxt, drop_nxt, air_nxt} = 3'b000;
              sub_nxt  = slms_pkg::SS_IDLE;
              lift_nxt = slms_pkg::LS_IDLE;
              ev       = slms_pkg::EV_REFILL_STOP;
            end
          end
          default: begin
            {motor_nxt, drop_nxt, air_nxt} = 3'b000;
            sub_nxt  = slms_pkg::SS_IDLE;
            lift_nxt = slms_pkg::LS_IDLE;
          end
        endcase
      end
    end
  end

  // request register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r.motor_on       <= motor_nxt;
      out_r.drop_valve_on  <= drop_nxt;
      out_r.air_valve_on   <= air_nxt;
      out_r.lift_state     <= lift_nxt;
      out_r.log_event      <= ev;
      out_r.event_duration <= dur;
    end
  end

  // sequencer state advances as a request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= slms_pkg::SS_IDLE;
      start_r     <= 32'd0;
      prev_up_r   <= 1'b0;
      prev_down_r <= 1'b0;
      prev_lock_r <= 1'b0;
      motor_r     <= 1'b0;
      drop_r      <= 1'b0;
      air_r       <= 1'b0;
      lift_r      <= slms_pkg::LS_IDLE;
    end else if (adv) begin
      sub_r       <= sub_nxt;
      start_r     <= start_nxt;
      prev_up_r   <= prev_up_nxt;
      prev_down_r <= prev_down_nxt;
      prev_lock_r <= prev_lock_nxt;
      motor_r     <= motor_nxt;
      drop_r      <= drop_nxt;
      air_r       <= air_nxt;
      lift_r      <= lift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valve_delay_r <= slms_pkg::VALVE_DELAY_RST;
      hold_r        <= slms_pkg::HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slms_pkg::CFG_VALVE_DELAY: valve_delay_r <= cfg_wdata;
        slms_pkg::CFG_HOLD:        hold_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stop events always land in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.log_event == slms_pkg::EV_UP_STOP_LIMIT ||
                  out_r.log_event == slms_pkg::EV_UP_STOP_REL ||
                  out_r.log_event == slms_pkg::EV_DOWN_STOP ||
                  out_r.log_event == slms_pkg::EV_LOCK_STOP ||
                  out_r.log_event == slms_pkg::EV_REFILL_STOP)
      |-> out_r.lift_state == slms_pkg::LS_IDLE)
    else $error("stop event without idle lift state");

  // only stop events carry a duration
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.event_duration != 16'd0
      |-> (out_r.log_event == slms_pkg::EV_UP_STOP_LIMIT ||
           out_r.log_event == slms_pkg::EV_UP_STOP_REL ||
           out_r.log_event == slms_pkg::EV_DOWN_STOP ||
           out_r.log_event == slms_pkg::EV_LOCK_STOP ||
           out_r.log_event == slms_pkg::EV_REFILL_STOP))
    else $error("duration on a non-stop result");

  // an estop or light curtain leaves all drives off
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_r.action == slms_pkg::ACT_ESTOP || in_r.action == slms_pkg::ACT_CURTAIN)
      |=> !motor_r && !drop_r && !air_r && sub_r == slms_pkg::SS_IDLE)
    else $error("drives not dropped after estop");

  // back-pressure only while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_vld_r && out_stall)
    else $error("input stalled without a waiting result");

endmodule

[tb/tb.sv]
// Self-checking testbench for the scissor lift motion sequencer.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_TAIL  = 4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RISING, ST_DPREP, ST_DHOLD, ST_DROP, ST_LOCK, ST_REFILL
  } seq_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  slms_pkg::in_item_t    in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  slms_pkg::out_item_t   out_data;
  logic                  cfg_we = 1'b0;
  logic [0:0]            cfg_index = slms_pkg::CFG_VALVE_DELAY;
  logic [15:0]           cfg_wdata = '0;

  // sequencer copy kept by the testbench
  seq_state_t            seq_state = ST_IDLE;
  logic [31:0]           act_start_ms = '0;
  logic                  last_up = 1'b0, last_down = 1'b0, last_lock = 1'b0;
  logic                  motor_q = 1'b0, drop_q = 1'b0, air_q = 1'b0;
  slms_pkg::lift_state_t lift_q = slms_pkg::LS_IDLE;
  logic [15:0]           valve_delay_cfg = slms_pkg::VALVE_DELAY_RST;
  logic [15:0]           hold_cfg = slms_pkg::HOLD_RST;

  slms_pkg::out_item_t   expected_results[$];
  int                    mismatch_count = 0;
  int                    results_seen = 0;
  int                    items_sent = 0;
  bit                    calm = 1'b0;
  logic [31:0]           ms_clock = '0;

  scissor_lift_motion_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic bit chance(int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void set_drives(logic m, logic d, logic a);
    motor_q = m;
    drop_q = d;
    air_q = a;
  endfunction

  function automatic void go_idle();
    set_drives(1'b0, 1'b0, 1'b0);
    seq_state = ST_IDLE;
    lift_q = slms_pkg::LS_IDLE;
  endfunction

  function automatic slms_pkg::out_item_t lift_predict(slms_pkg::in_item_t r);
    slms_pkg::out_item_t  res;
    slms_pkg::log_event_t ev;
    logic [15:0]          dur;
    logic [15:0]          held_sat;
    logic [31:0]          el;
    ev = slms_pkg::EV_NONE;
    dur = '0;
    el = r.now_ms - act_start_ms;
    held_sat = (el > 32'h0000_FFFF) ? slms_pkg::DUR_SAT : el[15:0];
    if (r.action == slms_pkg::ACT_ESTOP || r.action == slms_pkg::ACT_CURTAIN) begin
      // lift state and button history survive an alarm
      set_drives(1'b0, 1'b0, 1'b0);
      seq_state = ST_IDLE;
    end else if (r.action == slms_pkg::ACT_CLEAR) begin
      seq_state = ST_IDLE;
    end else begin
      if (r.up_button && r.down_button) begin
        set_drives(1'b0, 1'b0, 1'b0);
        if (seq_state != ST_IDLE) go_idle();
      end else begin
        case (seq_state)
          ST_IDLE: begin
            if (r.up_button && r.refill_button && !r.down_button && !r.lock_button) begin
              set_drives(1'b1, 1'b0, 1'b0);
              act_start_ms = r.now_ms;
              seq_state = ST_REFILL;
              lift_q = slms_pkg::LS_REFILLING;
              ev = slms_pkg::EV_REFILL_START;
            end else if (r.lock_button && !last_lock) begin
              set_drives(1'b0, 1'b1, 1'b0);
              act_start_ms = r.now_ms;
              seq_state = ST_LOCK;
              lift_q = slms_pkg::LS_LOCKED;
              ev = slms_pkg::EV_LOCK_START;
            end else if (r.up_button && !last_up && !r.down_button && !r.lock_button &&
                         !r.upper_limit_in) begin
              motor_q = 1'b1;
              act_start_ms = r.now_ms;
              seq_state = ST_RISING;
              lift_q = slms_pkg::LS_RISING;
              ev = slms_pkg::EV_UP_START;
            end else if (r.down_button && !last_down) begin
              motor_q = 1'b1;
              act_start_ms = r.now_ms;
              seq_state = ST_DPREP;
              lift_q = slms_pkg::LS_DROPPING;
              ev = slms_pkg::EV_DOWN_START;
            end
          end
          ST_RISING: begin
            if (r.upper_limit_in) begin
              dur = held_sat;
              go_idle();
              ev = slms_pkg::EV_UP_STOP_LIMIT;
            end else if (!r.up_button) begin
              dur = held_sat;
              go_idle();
              ev = slms_pkg::EV_UP_STOP_REL;
            end
          end
          ST_DPREP, ST_DHOLD, ST_DROP: begin
            if (!r.down_button) begin
              dur = held_sat;
              go_idle();
              ev = slms_pkg::EV_DOWN_STOP;
            end else if (r.lower_limit_in) begin
              set_drives(1'b0, 1'b1, 1'b0);
              seq_state = ST_DROP;
              lift_q = slms_pkg::LS_DROPPING;
            end else if (r.upper_limit_in || r.lock_button) begin
              // forced fast drop: air valve open as well
              set_drives(1'b0, 1'b1, 1'b1);
              seq_state = ST_DROP;
              lift_q = slms_pkg::LS_DROPPING;
            end else if (seq_state == ST_DPREP) begin
              if (el >= {16'd0, valve_delay_cfg}) begin
                air_q = 1'b1;
                seq_state = ST_DHOLD;
              end
            end else if (seq_state == ST_DHOLD) begin
              if (el >= {16'd0, hold_cfg}) begin
                motor_q = 1'b0;
                drop_q = 1'b1;
                seq_state = ST_DROP;
              end
            end
          end
          ST_LOCK: begin
            if (!r.lock_button) begin
              dur = held_sat;
              go_idle();
              ev = slms_pkg::EV_LOCK_STOP;
            end else begin
              set_drives(1'b0, 1'b1, 1'b0);
            end
          end
          ST_REFILL: begin
            if (!r.up_button || !r.refill_button || r.down_button || r.lock_button) begin
              dur = held_sat;
              go_idle();
              ev = slms_pkg::EV_REFILL_STOP;
            end
          end
          default: go_idle();
        endcase
      end
      last_up = r.up_button;
      last_down = r.down_button;
      last_lock = r.lock_button;
    end
    res.motor_on = motor_q;
    res.drop_valve_on = drop_q;
    res.air_valve_on = air_q;
    res.lift_state = lift_q;
    res.log_event = ev;
    res.event_duration = dur;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_result(slms_pkg::out_item_t got);
    slms_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no request outstanding");
      return;
    end
    want = expected_results.pop_front();
    compare_field("motor_on", 32'(got.motor_on), 32'(want.motor_on));
    compare_field("drop_valve_on", 32'(got.drop_valve_on), 32'(want.drop_valve_on));
    compare_field("air_valve_on", 32'(got.air_valve_on), 32'(want.air_valve_on));
    compare_field("lift_state", 32'(got.lift_state), 32'(want.lift_state));
    compare_field("log_event", 32'(got.log_event), 32'(want.log_event));
    compare_field("event_duration", 32'(got.event_duration), 32'(want.event_duration));
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // receiver back-pressure
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("scissor_lift_motion_sequencer test failed");
    $finish;
  end

  task automatic send_request(slms_pkg::in_item_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(lift_predict(r));
    items_sent++;
  endtask

  // hold off until every outstanding request has produced its result
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(slms_pkg::cfg_index_t idx, logic [15:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == slms_pkg::CFG_VALVE_DELAY) valve_delay_cfg = val;
    else hold_cfg = val;
  endtask

  task automatic poll(bit up, bit dn, bit lk, bit rf, bit hi, bit lo);
    slms_pkg::in_item_t r;
    r.action = slms_pkg::ACT_POLL;
    {r.up_button, r.down_button, r.lock_button, r.refill_button} = {up, dn, lk, rf};
    {r.upper_limit_in, r.lower_limit_in} = {hi, lo};
    r.now_ms = ms_clock;
    send_request(r);
  endtask

  // events ignore buttons and time, so randomise them
  task automatic alarm(slms_pkg::action_t a);
    slms_pkg::in_item_t r;
    r.action = a;
    {r.up_button, r.down_button, r.lock_button, r.refill_button,
     r.upper_limit_in, r.lower_limit_in} = 6'($urandom_range(0, 63));
    r.now_ms = $urandom;
    send_request(r);
  endtask

  function automatic void step_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) ms_clock += $urandom_range(0, 40);
    else if (r < 88) ms_clock += $urandom_range(41, 1500);
    else if (r < 98) ms_clock += $urandom_range(1501, 80000);
    else ms_clock += $urandom;
  endfunction

  // poll with random time advance, the odd alarm and the odd bouncing contact
  task automatic noisy_poll(bit up, bit dn, bit lk, bit rf, bit hi, bit lo);
    slms_pkg::in_item_t r;
    step_clock();
    if (chance(25)) begin
      case ($urandom_range(0, 2))
        0: alarm(slms_pkg::ACT_ESTOP);
        1: alarm(slms_pkg::ACT_CURTAIN);
        default: alarm(slms_pkg::ACT_CLEAR);
      endcase
    end
    r.action = slms_pkg::ACT_POLL;
    {r.up_button, r.down_button, r.lock_button, r.refill_button} = {up, dn, lk, rf};
    {r.upper_limit_in, r.lower_limit_in} = {hi, lo};
    r.now_ms = ms_clock;
    if (chance(20)) r[32 + $urandom_range(0, 5)] ^= 1'b1;
    send_request(r);
  endtask

  task automatic test_alarm_events();
    alarm(slms_pkg::ACT_ESTOP);
    alarm(slms_pkg::ACT_CURTAIN);
    alarm(slms_pkg::ACT_CLEAR);
  endtask

  task automatic test_rise_and_stop();
    ms_clock = 32'd1000;
    poll(1, 0, 0, 0, 0, 0);
    ms_clock = 32'd1250;
    poll(1, 0, 0, 0, 1, 0);
    ms_clock = 32'd1300;
    poll(0, 0, 0, 0, 0, 0);
    ms_clock = 32'd1400;
    poll(1, 0, 0, 0, 0, 0);
    ms_clock = 32'd1401;
    poll(0, 0, 0, 0, 0, 0);
  endtask

  // timed down sequence at reset timings, chord stop, forced and lower-limit drop
  task automatic test_down_sequence();
    ms_clock = 32'd100_000;
    poll(0, 1, 0, 0, 0, 0);
    ms_clock = 32'd100_000 + 32'(slms_pkg::VALVE_DELAY_RST) - 32'd1;
    poll(0, 1, 0, 0, 0, 0);
    ms_clock = 32'd100_000 + 32'(slms_pkg::VALVE_DELAY_RST);
    poll(0, 1, 0, 0, 0, 0);
    ms_clock = 32'd100_000 + 32'(slms_pkg::HOLD_RST);
    poll(0, 1, 0, 0, 0, 0);
    ms_clock += 5;
    poll(1, 1, 0, 0, 0, 0);
    ms_clock += 5;
    poll(0, 0, 0, 0, 0, 0);
    ms_clock += 5;
    poll(0, 1, 0, 0, 0, 0);
    ms_clock += 5;
    poll(0, 1, 0, 0, 1, 0);
    ms_clock += 5;
    poll(0, 1, 0, 0, 0, 1);
    ms_clock += 5;
    poll(0, 0, 0, 0, 0, 0);
  endtask

  // lock duration saturates; refill straddles the time wrap
  task automatic test_lock_and_refill();
    ms_clock = 32'd200_000;
    poll(0, 0, 1, 0, 0, 0);
    ms_clock += 10;
    poll(0, 0, 1, 0, 0, 0);
    ms_clock += 100_000;
    poll(0, 0, 0, 0, 0, 0);
    ms_clock = 32'hFFFF_FFF0;
    poll(1, 0, 0, 1, 0, 0);
    ms_clock = 32'h0000_0020;
    poll(1, 0, 0, 1, 0, 0);
    ms_clock = 32'h0000_0030;
    poll(1, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random_traffic(int n_items);
    int          stop_at;
    int          next_cfg;
    int          phase;
    int          len;
    int          sel;
    logic [15:0] dly;
    logic [15:0] hld;
    stop_at = items_sent + n_items;
    next_cfg = items_sent;
    phase = 0;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        sel = (phase < 3) ? phase : $urandom_range(0, 4);
        case (sel)
          0: begin dly = 16'h0000; hld = 16'h0000; end
          1: begin dly = 16'hFFFF; hld = 16'hFFFF; end
          2: begin dly = 16'($urandom_range(0, 60)); hld = 16'($urandom_range(0, 120)); end
          3: begin dly = slms_pkg::VALVE_DELAY_RST; hld = slms_pkg::HOLD_RST; end
          default: begin dly = 16'($urandom); hld = 16'($urandom); end
        endcase
        write_reg(slms_pkg::CFG_VALVE_DELAY, dly);
        write_reg(slms_pkg::CFG_HOLD, hld);
        phase++;
        next_cfg = items_sent + $urandom_range(60, 160);
      end else if (chance(30)) begin
        settle();
      end
      calm = chance(8);
      len = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int i = 0; i < len; i++)
            noisy_poll(1, 0, 0, 0, (i == len - 1) && chance(2), 0);
          noisy_poll(0, 0, 0, 0, 0, 0);
        end
        2, 3: begin
          for (int i = 0; i < len + 2; i++)
            noisy_poll(0, 1, chance(12), 0, chance(12), chance(8));
          if (chance(5)) noisy_poll(1, 1, 0, 0, 0, 0);
          noisy_poll(0, 0, 0, 0, 0, 0);
        end
        4: begin
          for (int i = 0; i < len; i++)
            noisy_poll(0, 0, 1, 0, chance(2), chance(2));
          noisy_poll(0, 0, 0, 0, 0, 0);
        end
        5: begin
          for (int i = 0; i < len; i++)
            noisy_poll(1, 0, 0, 1, chance(2), chance(2));
          case ($urandom_range(0, 3))
            0: noisy_poll(0, 0, 0, 1, 0, 0);
            1: noisy_poll(1, 0, 0, 0, 0, 0);
            2: noisy_poll(1, 1, 0, 1, 0, 0);
            default: noisy_poll(1, 0, 1, 1, 0, 0);
          endcase
        end
        6: noisy_poll(1, 1, chance(2), chance(2), chance(2), chance(2));
        default: begin
          for (int i = 0; i < len; i++) begin
            if (chance(4)) alarm(slms_pkg::action_t'($urandom_range(1, 3)));
            else noisy_poll(chance(2), chance(2), chance(2), chance(2), chance(2), chance(2));
          end
        end
      endcase
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_alarm_events();
    test_rise_and_stop();
    test_down_sequence();
    test_lock_and_refill();
    test_random_traffic(980);
    settle();
    if (mismatch_count == 0) begin
      $display("scissor_lift_motion_sequencer test passed");
    end else begin
      $display("scissor_lift_motion_sequencer test failed");
    end
    $finish;
  end

endmodule
